// File: hw/rtl/hqss_pkg.sv
// Shared types and constants for the hex/quad simplex splitter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hqss_pkg;

   localparam int ID_W        = 32;
   localparam int TAG_W       = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_QUAD = 1'b0;
   localparam logic OP_HEX  = 1'b1;

   localparam logic KIND_TRI = 1'b0;
   localparam logic KIND_TET = 1'b1;

   localparam logic [2:0] CNT_QUAD  = 3'd2;
   localparam logic [2:0] CNT_FIVE  = 3'd5;
   localparam logic [2:0] CNT_PRISM = 3'd6;

   typedef logic [ID_W-1:0]  id_type;
   typedef logic [TAG_W-1:0] tag_type;

   typedef struct packed {
      logic    op;
      id_type  corner_0;
      id_type  corner_1;
      id_type  corner_2;
      id_type  corner_3;
      id_type  corner_4;
      id_type  corner_5;
      id_type  corner_6;
      id_type  corner_7;
      tag_type region_tag;
   } req_type;

   typedef struct packed {
      logic    simplex_kind;
      id_type  vertex_a;
      id_type  vertex_b;
      id_type  vertex_c;
      id_type  vertex_d;
      tag_type tag_out;
      logic    last_of_run;
   } rsp_type;

   typedef logic [2:0]       idx_type;
   typedef idx_type [7:0]    idx_list_type;
   typedef idx_type [5:0]    prism_type;
   typedef idx_type [3:0]    simp_type;
   typedef simp_type [5:0]   simp_set_type;
   typedef simp_type [2:0]   prism_simp_type;
   typedef id_type [7:0]     id_vec_type;
   typedef logic [7:0][7:0]  cmp_type;
   typedef logic [2:0]       count_type;

   typedef struct packed {
      logic       op;
      id_vec_type ids;
      tag_type    tag;
   } item_type;

   typedef struct packed {
      logic         kind;
      count_type    count;
      logic         prism;
      simp_set_type simp;
      prism_type    pa;
      prism_type    pb;
   } plan_type;

   typedef struct packed {
      logic         kind;
      count_type    count;
      simp_set_type simp;
      id_vec_type   ids;
      tag_type      tag;
   } job_type;

endpackage

`default_nettype wire

// File: hw/rtl/hqss_front.sv
// Front pipeline: takes elements, builds the compare matrix, orients the element
// and plans every simplex as corner indices. Depends on hqss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hqss_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hqss_pkg::req_type req_data,
   output logic              job_valid,
   input  logic              job_stall,
   output hqss_pkg::job_type job_data
);
   import hqss_pkg::*;

   // first-listed minimum over the first n entries of s, ties to the earlier entry
   function automatic idx_type min_pos(input cmp_type lt, input idx_list_type s,
                                       input logic [3:0] n);
      idx_type r;
      logic    win;
      r = '0;
      for (int j = 0; j < 8; j++) begin
         win = (j < int'(n));
         for (int i = 0; i < 8; i++) begin
            if (i < j && !lt[s[j]][s[i]]) win = 1'b0;
            if (i > j && i < int'(n) && lt[s[i]][s[j]]) win = 1'b0;
         end
         if (win) r = 3'(j);
      end
      return r;
   endfunction

   function automatic logic [1:0] add3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   function automatic logic [1:0] sub3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] s;
      s = {1'b0, a} + 3'd3 - {1'b0, b};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   function automatic simp_type mk_simp(input idx_type a, input idx_type b,
                                        input idx_type c, input idx_type d);
      simp_type r;
      r[0] = a;
      r[1] = b;
      r[2] = c;
      r[3] = d;
      return r;
   endfunction

   function automatic prism_type mk_prism(input idx_type a, input idx_type b,
                                          input idx_type c, input idx_type d,
                                          input idx_type e, input idx_type f);
      prism_type r;
      r[0] = a;
      r[1] = b;
      r[2] = c;
      r[3] = d;
      r[4] = e;
      r[5] = f;
      return r;
   endfunction

   function automatic prism_type prism_rot(input cmp_type lt, input prism_type pl);
      idx_list_type s;
      idx_type      m;
      logic [1:0]   r;
      prism_type    n;
      s = '0;
      for (int k = 0; k < 6; k++) s[k] = pl[k];
      m = min_pos(lt, s, 4'd6);
      for (int k = 0; k < 3; k++) begin
         if (m < 3'd3) begin
            r        = add3(2'(k), m[1:0]);
            n[k]     = pl[{1'b0, r}];
            n[k + 3] = pl[{1'b0, r} + 3'd3];
         end else begin
            r        = sub3(2'(m - 3'd3), 2'(k));
            n[k]     = pl[{1'b0, r} + 3'd3];
            n[k + 3] = pl[{1'b0, r}];
         end
      end
      return n;
   endfunction

   // one tet off the prism, then the remaining pyramid into two tets
   function automatic prism_simp_type prism_tets(input cmp_type lt, input prism_type n);
      idx_list_type   s;
      idx_type        pm;
      simp_type       q;
      simp_type       r;
      logic [1:0]     t;
      prism_simp_type o;
      q[0] = n[4];
      q[1] = n[5];
      q[2] = n[2];
      q[3] = n[1];
      s = '0;
      for (int k = 0; k < 4; k++) s[k] = q[k];
      pm = min_pos(lt, s, 4'd4);
      for (int k = 0; k < 4; k++) begin
         t    = 2'(k) + pm[1:0];
         r[k] = q[t];
      end
      o[0] = mk_simp(n[3], n[5], n[4], n[0]);
      o[1] = mk_simp(r[0], r[2], r[3], n[0]);
      o[2] = mk_simp(r[0], r[1], r[2], n[0]);
      return o;
   endfunction

   logic         ok1, ok2, ok3, ok4, ok5;
   logic         s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   item_type     s1_item_in, s1_item_ff, s2_item_ff, s3_item_ff, s4_item_ff, s5_item_ff;
   cmp_type      s2_cmp_in, s2_cmp_ff, s3_cmp_ff, s4_cmp_ff, s5_cmp_ff;
   idx_list_type s3_perm_in, s3_perm_ff;
   plan_type     s4_plan_in, s4_plan_ff, s5_plan_in, s5_plan_ff;
   idx_list_type ident;

   assign ok5       = !s5_valid_ff || !job_stall;
   assign ok4       = !s4_valid_ff || ok5;
   assign ok3       = !s3_valid_ff || ok4;
   assign ok2       = !s2_valid_ff || ok3;
   assign ok1       = !s1_valid_ff || ok2;
   assign req_stall = !ok1;

   always_comb begin
      for (int k = 0; k < 8; k++) ident[k] = 3'(k);
   end

   always_comb begin
      s1_item_in.op     = req_data.op;
      s1_item_in.ids[0] = req_data.corner_0;
      s1_item_in.ids[1] = req_data.corner_1;
      s1_item_in.ids[2] = req_data.corner_2;
      s1_item_in.ids[3] = req_data.corner_3;
      s1_item_in.ids[4] = req_data.corner_4;
      s1_item_in.ids[5] = req_data.corner_5;
      s1_item_in.ids[6] = req_data.corner_6;
      s1_item_in.ids[7] = req_data.corner_7;
      s1_item_in.tag    = req_data.region_tag;
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            s2_cmp_in[i][j] = s1_item_ff.ids[i] < s1_item_ff.ids[j];
         end
      end
   end

   // hex orientation: smallest id to corner 0, mirrored between faces if needed
   always_comb begin : perm_calc
      idx_type m;
      idx_type kk;
      m = min_pos(s2_cmp_ff, ident, 4'd8);
      for (int k = 0; k < 8; k++) begin
         kk = 3'(k);
         s3_perm_in[k] = {m[2] ^ kk[2], m[2] ? (m[1:0] - kk[1:0]) : (m[1:0] + kk[1:0])};
      end
   end

   always_comb begin : plan_calc
      idx_list_type p;
      idx_list_type sa, sb, sc;
      idx_type      wa, wb, wc, qm;
      logic [1:0]   qn [4];
      p  = s3_perm_ff;
      sa = '0;
      sb = '0;
      sc = '0;
      sa[0] = p[2]; sa[1] = p[3]; sa[2] = p[6]; sa[3] = p[7];
      sb[0] = p[4]; sb[1] = p[5]; sb[2] = p[6]; sb[3] = p[7];
      sc[0] = p[5]; sc[1] = p[6]; sc[2] = p[2]; sc[3] = p[1];
      wa = min_pos(s3_cmp_ff, sa, 4'd4);
      wb = min_pos(s3_cmp_ff, sb, 4'd4);
      wc = min_pos(s3_cmp_ff, sc, 4'd4);
      qm = min_pos(s3_cmp_ff, ident, 4'd4);
      for (int k = 0; k < 4; k++) qn[k] = 2'(k) + qm[1:0];

      s4_plan_in       = '0;
      s4_plan_in.kind  = KIND_TET;
      s4_plan_in.count = CNT_PRISM;
      s4_plan_in.prism = 1'b1;
      if (s3_item_ff.op == OP_QUAD) begin
         s4_plan_in.kind    = KIND_TRI;
         s4_plan_in.count   = CNT_QUAD;
         s4_plan_in.prism   = 1'b0;
         s4_plan_in.simp[0] = mk_simp({1'b0, qn[0]}, {1'b0, qn[2]}, {1'b0, qn[3]}, '0);
         s4_plan_in.simp[1] = mk_simp({1'b0, qn[0]}, {1'b0, qn[1]}, {1'b0, qn[2]}, '0);
      end else if (wa == 3'd1 || wa == 3'd2) begin
         s4_plan_in.pa = mk_prism(p[0], p[5], p[1], p[3], p[6], p[2]);
         s4_plan_in.pb = mk_prism(p[5], p[0], p[4], p[6], p[3], p[7]);
      end else if (wb == 3'd0 || wb == 3'd2) begin
         s4_plan_in.pa = mk_prism(p[4], p[6], p[5], p[0], p[2], p[1]);
         s4_plan_in.pb = mk_prism(p[4], p[7], p[6], p[0], p[3], p[2]);
      end else if (wc == 3'd3 || wc == 3'd1) begin
         s4_plan_in.pa = mk_prism(p[5], p[6], p[1], p[4], p[7], p[0]);
         s4_plan_in.pb = mk_prism(p[1], p[6], p[2], p[0], p[7], p[3]);
      end else begin
         s4_plan_in.count   = CNT_FIVE;
         s4_plan_in.prism   = 1'b0;
         s4_plan_in.simp[0] = mk_simp(p[5], p[4], p[7], p[0]);
         s4_plan_in.simp[1] = mk_simp(p[0], p[7], p[5], p[2]);
         s4_plan_in.simp[2] = mk_simp(p[5], p[0], p[2], p[1]);
         s4_plan_in.simp[3] = mk_simp(p[0], p[7], p[2], p[3]);
         s4_plan_in.simp[4] = mk_simp(p[5], p[2], p[7], p[6]);
      end
   end

   always_comb begin
      s5_plan_in    = s4_plan_ff;
      s5_plan_in.pa = prism_rot(s4_cmp_ff, s4_plan_ff.pa);
      s5_plan_in.pb = prism_rot(s4_cmp_ff, s4_plan_ff.pb);
   end

   always_comb begin
      job_valid      = s5_valid_ff;
      job_data.kind  = s5_plan_ff.kind;
      job_data.count = s5_plan_ff.count;
      job_data.ids   = s5_item_ff.ids;
      job_data.tag   = s5_item_ff.tag;
      job_data.simp  = s5_plan_ff.simp;
      if (s5_plan_ff.prism) begin
         job_data.simp[2:0] = prism_tets(s5_cmp_ff, s5_plan_ff.pa);
         job_data.simp[5:3] = prism_tets(s5_cmp_ff, s5_plan_ff.pb);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (ok1) s1_valid_ff <= req_valid;
         if (ok2) s2_valid_ff <= s1_valid_ff;
         if (ok3) s3_valid_ff <= s2_valid_ff;
         if (ok4) s4_valid_ff <= s3_valid_ff;
         if (ok5) s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ok1) s1_item_ff <= s1_item_in;
      if (ok2) begin
         s2_item_ff <= s1_item_ff;
         s2_cmp_ff  <= s2_cmp_in;
      end
      if (ok3) begin
         s3_item_ff <= s2_item_ff;
         s3_cmp_ff  <= s2_cmp_ff;
         s3_perm_ff <= s3_perm_in;
      end
      if (ok4) begin
         s4_item_ff <= s3_item_ff;
         s4_cmp_ff  <= s3_cmp_ff;
         s4_plan_ff <= s4_plan_in;
      end
      if (ok5) begin
         s5_item_ff <= s4_item_ff;
         s5_cmp_ff  <= s4_cmp_ff;
         s5_plan_ff <= s5_plan_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/hqss_queue.sv
// Short job queue between the front pipeline and the output sequencer.
// Depends on hqss_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module hqss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  hqss_pkg::job_type in_data,
   output logic              out_valid,
   input  logic              out_pop,
   output hqss_pkg::job_type out_data
);
   import hqss_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;

   assign in_stall  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = in_valid && !in_stall;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (out_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, out_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule

`default_nettype wire

// File: hw/rtl/hqss_back.sv
// Output sequencer: walks the planned simplices of the head job, one per cycle when
// not stalled, into a registered result stage. Depends on hqss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hqss_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_pop,
   input  hqss_pkg::job_type job_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hqss_pkg::rsp_type rsp_data
);
   import hqss_pkg::*;

   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   count_type idx_ff, idx_in;
   logic      out_free, emit, last;
   simp_type  cur;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = job_valid && out_free;
   assign last      = (idx_ff == job_data.count - 3'd1);
   assign job_pop   = emit && last;
   assign cur       = job_data.simp[idx_ff];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      idx_in       = emit ? (last ? '0 : idx_ff + 3'd1) : idx_ff;
      rsp_valid_in = out_free ? job_valid : rsp_valid_ff;
      rsp_data_in.simplex_kind = job_data.kind;
      rsp_data_in.vertex_a     = job_data.ids[cur[0]];
      rsp_data_in.vertex_b     = job_data.ids[cur[1]];
      rsp_data_in.vertex_c     = job_data.ids[cur[2]];
      rsp_data_in.vertex_d     = (job_data.kind == KIND_TET) ? job_data.ids[cur[3]] : '0;
      rsp_data_in.tag_out      = job_data.tag;
      rsp_data_in.last_of_run  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/hex_quad_simplex_splitter.sv
// Top level of the hex/quad simplex splitter: front pipeline, job queue and
// output sequencer. Depends on hqss_pkg, hqss_front, hqss_queue, hqss_back.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/req_stall | hqss_pkg::req_type (one element)
//   rsp     | out | rsp_valid/rsp_stall | hqss_pkg::rsp_type (one simplex)
//
// A quad gives 2 results, a hex 5 or 6; the result port moves one per cycle
// while rsp_stall is low. With no stall, the first result passes through the
// 5 front stages, the queue and the output register. Reset clears all valid state.
// rsp_stall holds the output register; the 2-entry queue and front pipeline keep
// taking transactions until both are full.
`timescale 1ns / 1ps
`default_nettype none

module hex_quad_simplex_splitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hqss_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hqss_pkg::rsp_type rsp_data
);
   import hqss_pkg::*;

   logic    fq_valid, fq_stall;
   job_type fq_data;
   logic    qb_valid, qb_pop;
   job_type qb_data;

   hqss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (fq_valid),
      .job_stall (fq_stall),
      .job_data  (fq_data)
   );

   hqss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_stall  (fq_stall),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_pop   (qb_pop),
      .out_data  (qb_data)
   );

   hqss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_pop   (qb_pop),
      .job_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hw/rtl/hqss_check.sv
// Port-level checker for the simplex splitter, bound to the top level.
// Depends on hqss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hqss_check (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hqss_pkg::rsp_type rsp_data
);
   import hqss_pkg::*;

   logic       rsp_acc;
   logic [2:0] run_cnt_ff;
   tag_type    prev_tag_ff;
   logic       prev_kind_ff;

   assign rsp_acc = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff   <= '0;
         prev_tag_ff  <= '0;
         prev_kind_ff <= 1'b0;
      end else if (rsp_acc) begin
         run_cnt_ff   <= rsp_data.last_of_run ? 3'd0 : run_cnt_ff + 3'd1;
         prev_tag_ff  <= rsp_data.tag_out;
         prev_kind_ff <= rsp_data.simplex_kind;
      end
   end

   a_tri_no_fourth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.simplex_kind == KIND_TRI |-> rsp_data.vertex_d == '0)
      else $error("triangle carries a fourth vertex");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_run_uniform: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && run_cnt_ff != 3'd0 |->
         rsp_data.tag_out == prev_tag_ff && rsp_data.simplex_kind == prev_kind_ff)
      else $error("tag or kind changed inside a run");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_data.last_of_run |->
         (rsp_data.simplex_kind == KIND_TRI && run_cnt_ff == 3'd1) ||
         (rsp_data.simplex_kind == KIND_TET && (run_cnt_ff == 3'd4 || run_cnt_ff == 3'd5)))
      else $error("run ended at a wrong length");

   a_run_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_data.last_of_run |->
         (rsp_data.simplex_kind == KIND_TRI && run_cnt_ff == 3'd0) ||
         (rsp_data.simplex_kind == KIND_TET && run_cnt_ff < 3'd5))
      else $error("run too long");

endmodule

bind hex_quad_simplex_splitter hqss_check u_check (.*);

`default_nettype wire

// File: dv/tb_hex_quad_simplex_splitter.sv
// Testbench for hex_quad_simplex_splitter: directed and random quad/hex elements
// checked per simplex against an in-bench split predictor. Depends on hqss_pkg.
`timescale 1ns / 1ps

module tb_hex_quad_simplex_splitter;
   import hqss_pkg::*;

   localparam int          RANDOM_PER_PHASE = 66;
   localparam int          SETTLE_CYCLES    = 30;
   localparam int unsigned QUIET_LIMIT      = 4000;

   // diagonal corner sets that steer the hex split, last-listed entry at index 0
   localparam simp_type DIAG_SET_A = {3'd7, 3'd6, 3'd3, 3'd2};
   localparam simp_type DIAG_SET_B = {3'd7, 3'd6, 3'd5, 3'd4};
   localparam simp_type DIAG_SET_C = {3'd1, 3'd2, 3'd6, 3'd5};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic        req_went = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          mismatches = 0;
   req_type     pending_elements[$];
   rsp_type     expected_simplices[$];
   tag_type     element_tag;

   hex_quad_simplex_splitter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------- split predictor ----------------
   function automatic void add_simplex(logic kind, id_type a, id_type b, id_type c, id_type d);
      rsp_type s;
      s.simplex_kind = kind;
      s.vertex_a     = a;
      s.vertex_b     = b;
      s.vertex_c     = c;
      s.vertex_d     = d;
      s.tag_out      = element_tag;
      s.last_of_run  = 1'b0;
      expected_simplices.insert(expected_simplices.size(), s);
   endfunction

   // first-listed corner wins ties
   function automatic int lowest_corner(id_vec_type v, int count);
      int m, i;
      m = 0;
      for (i = 1; i < count; i++)
         if (v[i] < v[m]) m = i;
      return m;
   endfunction

   function automatic int lowest_of_set(id_vec_type v, simp_type corner_set);
      int m, i;
      m = 0;
      for (i = 1; i < 4; i++)
         if (v[corner_set[i]] < v[corner_set[m]]) m = i;
      return corner_set[m];
   endfunction

   function automatic void split_pyramid(id_type p0, id_type p1, id_type p2, id_type p3,
                                         id_type apex);
      id_vec_type c, n;
      int m, i;
      c = '0;
      n = '0;
      c[0] = p0; c[1] = p1; c[2] = p2; c[3] = p3;
      m = lowest_corner(c, 4);
      for (i = 0; i < 4; i++) n[(i + 4 - m) & 3] = c[i];
      add_simplex(KIND_TET, n[0], n[2], n[3], apex);
      add_simplex(KIND_TET, n[0], n[1], n[2], apex);
   endfunction

   function automatic void split_prism(id_type a0, id_type a1, id_type a2,
                                       id_type a3, id_type a4, id_type a5);
      id_vec_type c, n;
      int m, i;
      c = '0;
      n = '0;
      c[0] = a0; c[1] = a1; c[2] = a2; c[3] = a3; c[4] = a4; c[5] = a5;
      m = lowest_corner(c, 6);
      if (m < 3) begin
         for (i = 0; i < 3; i++) n[(i + 3 - m) % 3] = c[i];
         for (i = 3; i < 6; i++) n[(i + 3 - m) % 3 + 3] = c[i];
      end else begin
         // minimum on the far triangle: mirror the prism
         for (i = 3; i < 6; i++) n[(m + 3 - i) % 3] = c[i];
         for (i = 0; i < 3; i++) n[(m + 3 - i) % 3 + 3] = c[i];
      end
      add_simplex(KIND_TET, n[3], n[5], n[4], n[0]);
      split_pyramid(n[4], n[5], n[2], n[1], n[0]);
   endfunction

   function automatic void split_hex(id_vec_type c);
      id_vec_type n;
      int m, i;
      m = lowest_corner(c, 8);
      if (m < 4) begin
         for (i = 0; i < 4; i++) n[(i + 4 - m) & 3] = c[i];
         for (i = 4; i < 8; i++) n[((i - m) & 3) + 4] = c[i];
      end else begin
         for (i = 4; i < 8; i++) n[(m + 4 - i) & 3] = c[i];
         for (i = 0; i < 4; i++) n[((m + 4 - i) & 3) + 4] = c[i];
      end
      m = lowest_of_set(n, DIAG_SET_A);
      if (m == 6 || m == 3) begin
         split_prism(n[0], n[5], n[1], n[3], n[6], n[2]);
         split_prism(n[5], n[0], n[4], n[6], n[3], n[7]);
      end else begin
         m = lowest_of_set(n, DIAG_SET_B);
         if (m == 4 || m == 6) begin
            split_prism(n[4], n[6], n[5], n[0], n[2], n[1]);
            split_prism(n[4], n[7], n[6], n[0], n[3], n[2]);
         end else begin
            m = lowest_of_set(n, DIAG_SET_C);
            if (m == 1 || m == 6) begin
               split_prism(n[5], n[6], n[1], n[4], n[7], n[0]);
               split_prism(n[1], n[6], n[2], n[0], n[7], n[3]);
            end else begin
               add_simplex(KIND_TET, n[5], n[4], n[7], n[0]);
               add_simplex(KIND_TET, n[0], n[7], n[5], n[2]);
               add_simplex(KIND_TET, n[5], n[0], n[2], n[1]);
               add_simplex(KIND_TET, n[0], n[7], n[2], n[3]);
               add_simplex(KIND_TET, n[5], n[2], n[7], n[6]);
            end
         end
      end
   endfunction

   function automatic void split_quad(id_vec_type c);
      id_vec_type n;
      int m, i;
      n = '0;
      m = lowest_corner(c, 4);
      for (i = 0; i < 4; i++) n[(i + 4 - m) & 3] = c[i];
      add_simplex(KIND_TRI, n[0], n[2], n[3], '0);
      add_simplex(KIND_TRI, n[0], n[1], n[2], '0);
   endfunction

   function automatic void predict_simplices(req_type e);
      id_vec_type c;
      rsp_type    closing;
      c = {e.corner_7, e.corner_6, e.corner_5, e.corner_4,
           e.corner_3, e.corner_2, e.corner_1, e.corner_0};
      element_tag = e.region_tag;
      if (e.op == OP_HEX) split_hex(c);
      else split_quad(c);
      closing = expected_simplices.pop_back();
      closing.last_of_run = 1'b1;
      expected_simplices.insert(expected_simplices.size(), closing);
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic void queue_element(req_type e);
      pending_elements.insert(pending_elements.size(), e);
   endfunction

   function automatic id_vec_type corners(id_type c0, id_type c1, id_type c2, id_type c3,
                                          id_type c4, id_type c5, id_type c6, id_type c7);
      return {c7, c6, c5, c4, c3, c2, c1, c0};
   endfunction

   function automatic req_type mesh_element(logic op, id_vec_type c, tag_type tag);
      req_type e;
      e.op         = op;
      e.corner_0   = c[0];
      e.corner_1   = c[1];
      e.corner_2   = c[2];
      e.corner_3   = c[3];
      e.corner_4   = c[4];
      e.corner_5   = c[5];
      e.corner_6   = c[6];
      e.corner_7   = c[7];
      e.region_tag = tag;
      return e;
   endfunction

   // mix of tie-heavy small ids, ids near the top and full-range ids
   function automatic req_type random_element();
      id_vec_type  c;
      int          i;
      int unsigned pick;
      pick = $urandom_range(99, 0);
      for (i = 0; i < 8; i++) begin
         if (pick < 25) c[i] = $urandom_range(3, 0);
         else if (pick < 40) c[i] = 32'hFFFF_FFFF - $urandom_range(3, 0);
         else c[i] = $urandom();
      end
      return mesh_element(1'($urandom_range(1, 0)), c, 16'($urandom()));
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   task automatic wait_for_drain();
      while (pending_elements.size() > 0 || req_valid || expected_simplices.size() > 0)
         @(posedge clock);
   endtask

   // ---------------- driver ----------------
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      if (!reset && (!req_valid || req_went)) begin
         if (pending_elements.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_data  <= pending_elements.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         req_went <= 1'b0;
      end else begin
         req_went <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_simplices.size() == 0) begin
               $display("%0t: unexpected simplex transaction, expected none, actual %h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_simplices.pop_front();
               check_field("simplex_kind", 64'(want.simplex_kind),
                           64'(rsp_data.simplex_kind));
               check_field("vertex_a", 64'(want.vertex_a), 64'(rsp_data.vertex_a));
               check_field("vertex_b", 64'(want.vertex_b), 64'(rsp_data.vertex_b));
               check_field("vertex_c", 64'(want.vertex_c), 64'(rsp_data.vertex_c));
               check_field("vertex_d", 64'(want.vertex_d), 64'(rsp_data.vertex_d));
               check_field("tag_out", 64'(want.tag_out), 64'(rsp_data.tag_out));
               check_field("last_of_run", 64'(want.last_of_run),
                           64'(rsp_data.last_of_run));
            end
         end
         if (req_valid && !req_stall) predict_simplices(req_data);
      end
   end

   // ---------------- watchdog ----------------
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_hex_quad_simplex_splitter: done, errors");
      $finish;
   end

   // ---------------- sequence ----------------
   initial begin : stimulus
      id_vec_type c;
      int         i, k;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // hex split branches: second diagonal, first diagonal, third diagonal, five tets
      queue_element(mesh_element(OP_HEX, corners(0, 1, 2, 3, 4, 5, 6, 7), 16'h0001));
      queue_element(mesh_element(OP_HEX, corners(0, 10, 11, 1, 12, 13, 14, 15), 16'h0002));
      queue_element(mesh_element(OP_HEX, corners(0, 1, 5, 20, 21, 3, 22, 2), 16'h0004));
      queue_element(mesh_element(OP_HEX, corners(0, 20, 5, 21, 22, 3, 23, 2), 16'h0008));
      // minimum at every corner, rotation and mirror paths
      for (k = 0; k < 8; k++) begin
         for (i = 0; i < 8; i++) c[i] = 1000 + $urandom_range(999, 0);
         c[k] = 100;
         queue_element(mesh_element(OP_HEX, c, 16'($urandom())));
      end
      for (k = 0; k < 4; k++) begin
         for (i = 0; i < 8; i++) c[i] = 1000 + $urandom_range(999, 0);
         c[k] = 100;
         queue_element(mesh_element(OP_QUAD, c, 16'($urandom())));
      end
      // all-equal ids (degenerate output) and field extremes
      queue_element(mesh_element(OP_HEX, '0, '0));
      queue_element(mesh_element(OP_HEX, '1, '1));
      queue_element(mesh_element(OP_QUAD, '0, '0));
      queue_element(mesh_element(OP_QUAD, '1, '1));
      queue_element(mesh_element(OP_QUAD, corners(5, 5, 5, 5, 0, 0, 0, 0), 16'h8000));
      wait_for_drain();

      send_idle_pct = 25;
      recv_idle_pct = 83;
      for (i = 0; i < RANDOM_PER_PHASE; i++) queue_element(random_element());
      wait_for_drain();

      send_idle_pct = 83;
      recv_idle_pct = 25;
      for (i = 0; i < RANDOM_PER_PHASE; i++) queue_element(random_element());
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (i = 0; i < RANDOM_PER_PHASE; i++) queue_element(random_element());
      wait_for_drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_simplices.size() != 0) begin
         $display("%0t: %0d expected simplices never arrived", $time,
                  expected_simplices.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("tb_hex_quad_simplex_splitter: done, clean");
      else
         $display("tb_hex_quad_simplex_splitter: done, errors");
      $finish;
   end

endmodule
